// ----- sv/gfsc_pkg.sv -----
package gfsc_pkg;

  // Framing constants
  localparam logic [7:0]  SyncFirst  = 8'h24;
  localparam logic [7:0]  SyncSecond = 8'h40;
  localparam logic [15:0] CrcPoly    = 16'h1021;
  localparam logic [15:0] HeaderLen  = 16'd8;

  localparam int MaxFrameDef = 1024;
  localparam int OutDepth    = 3;

  // Hunt phase codes
  localparam logic [1:0] PhaseSync1 = 2'd0;
  localparam logic [1:0] PhaseSync2 = 2'd1;
  localparam logic [1:0] PhaseBody  = 2'd2;

  // Header byte positions, sync bytes counted
  localparam int PosCrcLo = 2;
  localparam int PosCrcHi = 3;
  localparam int PosIdLo  = 4;
  localparam int PosIdHi  = 5;
  localparam int PosLenLo = 6;
  localparam int PosLenHi = 7;

  // Frame status codes
  localparam logic [1:0] StatusGood   = 2'd0;
  localparam logic [1:0] StatusCrcBad = 2'd1;
  localparam logic [1:0] StatusBadLen = 2'd2;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  frame_status;
    logic [12:0] block_number;
    logic [2:0]  block_revision;
    logic [15:0] frame_bytes;
  } res_t;

  // CRC-16, MSB first, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- sv/gfsc_in_reg.sv -----
module gfsc_in_reg
  import gfsc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_stall_i,
  input  logic [7:0] data_byte_i,
  output in_word_t word_o
);

  logic       valid_q;
  logic       valid_d;
  logic [7:0] data_q;

  assign valid_d = in_valid_i & ~in_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_d) begin
      data_q <= data_byte_i;
    end
  end

  assign word_o.valid = valid_q;
  assign word_o.data  = data_q;

endmodule

// ----- sv/gfsc_parser.sv -----
module gfsc_parser
  import gfsc_pkg::*;
#(
  parameter int MaxFrame = MaxFrameDef
)(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_word_t word_i,
  output logic     res_valid_o,
  output res_t     res_o
);

  localparam int PosW = $clog2(MaxFrame + 1);

  logic [1:0]      phase_q, phase_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     len_q, len_d;
  logic [15:0]     exp_crc_q, exp_crc_d;
  logic [15:0]     crc_q, crc_d;
  logic [15:0]     ident_q, ident_d;

  logic [PosW:0]   pos_inc;
  logic            len_bad;
  logic            emit;
  logic [1:0]      status;
  logic [7:0]      b;

  assign b       = word_i.data;
  assign pos_inc = {1'b0, pos_q} + (PosW + 1)'(1);
  assign len_bad = (len_d < HeaderLen) || (len_d > 16'(MaxFrame)) || (len_d[1:0] != 2'b00);

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    len_d     = len_q;
    exp_crc_d = exp_crc_q;
    crc_d     = crc_q;
    ident_d   = ident_q;
    emit      = 1'b0;
    status    = StatusGood;

    if (word_i.valid) begin
      case (phase_q)
        PhaseSync1: begin
          if (b == SyncFirst) begin
            phase_d = PhaseSync2;
            pos_d   = PosW'(1);
          end
        end
        PhaseSync2: begin
          if (b == SyncSecond) begin
            phase_d = PhaseBody;
            pos_d   = PosW'(2);
            crc_d   = '0;
            len_d   = '0;
          end else if (b == SyncFirst) begin
            pos_d = PosW'(1);
          end else begin
            phase_d = PhaseSync1;
            pos_d   = '0;
          end
        end
        PhaseBody: begin
          case (pos_q)
            PosW'(PosCrcLo): exp_crc_d = {8'h00, b};
            PosW'(PosCrcHi): exp_crc_d = {b, exp_crc_q[7:0]};
            PosW'(PosIdLo):  ident_d   = {8'h00, b};
            PosW'(PosIdHi):  ident_d   = {b, ident_q[7:0]};
            PosW'(PosLenLo): len_d     = {8'h00, b};
            PosW'(PosLenHi): len_d     = {b, len_q[7:0]};
            default: ;
          endcase
          if (pos_q >= PosW'(PosIdLo)) begin
            crc_d = crc_byte(crc_q, b);
          end
          pos_d = pos_inc[PosW-1:0];

          if (pos_inc == (PosW + 1)'(HeaderLen)) begin
            if (len_bad) begin
              emit   = 1'b1;
              status = StatusBadLen;
            end else if (len_d == HeaderLen) begin
              emit   = 1'b1;
              status = (crc_d == exp_crc_d) ? StatusGood : StatusCrcBad;
            end
          end else if ((pos_inc > (PosW + 1)'(HeaderLen)) &&
                       ((16'(pos_inc) == len_d) || (pos_inc > (PosW + 1)'(MaxFrame)))) begin
            emit   = 1'b1;
            status = (crc_d == exp_crc_d) ? StatusGood : StatusCrcBad;
          end

          if (emit) begin
            phase_d = PhaseSync1;
            pos_d   = '0;
          end
        end
        default: begin
          phase_d = PhaseSync1;
          pos_d   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhaseSync1;
      pos_q     <= '0;
      len_q     <= '0;
      exp_crc_q <= '0;
      crc_q     <= '0;
      ident_q   <= '0;
    end else begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      len_q     <= len_d;
      exp_crc_q <= exp_crc_d;
      crc_q     <= crc_d;
      ident_q   <= ident_d;
    end
  end

  assign res_valid_o          = emit;
  assign res_o.frame_status   = status;
  assign res_o.block_number   = ident_d[12:0];
  assign res_o.block_revision = ident_d[15:13];
  assign res_o.frame_bytes    = len_d;

endmodule

// ----- sv/gfsc_out_fifo.sv -----
module gfsc_out_fifo
  import gfsc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t push_data_i,
  input  logic pending_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output res_t out_data_o
);

  localparam int CntW = $clog2(OutDepth + 1);
  localparam int PtrW = $clog2(OutDepth);

  res_t            mem_q [OutDepth];
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PtrW-1:0] wr_q, rd_q;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(OutDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign pop         = (cnt_q != '0) && !out_stall_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];

  // Room for the word in the input register and one more
  assign in_stall_o = ({1'b0, cnt_q} + (CntW + 1)'(pending_i)) >= (CntW + 1)'(OutDepth);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= '0;
      rd_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= ptr_next(wr_q);
      end
      if (pop) begin
        rd_q <= ptr_next(rd_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ----- sv/gnss_block_frame_sync_crc16_unit.sv -----
// Channel | Handshake               | Fields
// input   | in_valid_i / in_stall_o   | data_byte_i
// output  | out_valid_o / out_stall_i | frame_status_o, block_number_o, block_revision_o,
//         |                           | frame_bytes_o
//
// One byte per cycle while in_stall_o is low. A byte is registered, then sync/header/CRC logic runs on it
// in the next cycle; a result is written into a three-word output queue at the edge
// after acceptance and is offered from that edge on.
// Reset clears the hunt state, the queue and the valid flag of the input register.
// in_stall_o rises when the queued words and the word in the input register leave
// no room for one more.
module gnss_block_frame_sync_crc16_unit
  import gfsc_pkg::*;
#(
  parameter int MaxFrame = MaxFrameDef
)(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  frame_status_o,
  output logic [12:0] block_number_o,
  output logic [2:0]  block_revision_o,
  output logic [15:0] frame_bytes_o
);

  in_word_t in_word;
  logic     res_valid;
  res_t     res;
  res_t     out_data;

  gfsc_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .data_byte_i (data_byte_i),
    .word_o      (in_word)
  );

  gfsc_parser #(
    .MaxFrame (MaxFrame)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .word_i      (in_word),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  gfsc_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .pending_i   (in_word.valid),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign frame_status_o   = out_data.frame_status;
  assign block_number_o   = out_data.block_number;
  assign block_revision_o = out_data.block_revision;
  assign frame_bytes_o    = out_data.frame_bytes;

endmodule

// ----- dv/gnss_block_frame_sync_crc16_unit_tb.sv -----
`timescale 1ns / 100ps

module gnss_block_frame_sync_crc16_unit_tb
  import gfsc_pkg::*;
();

  class frame_scoreboard;
    logic [1:0]  phase;
    int          pos;
    logic [15:0] len_field;
    logic [15:0] crc_field;
    logic [15:0] crc_run;
    logic [15:0] ident;
    res_t        report_q[$];
    int          n_err;
    int          n_reports;
    int          n_status[3];

    function new();
      phase     = PhaseSync1;
      pos       = 0;
      len_field = '0;
      crc_field = '0;
      crc_run   = '0;
      ident     = '0;
      n_err     = 0;
      n_reports = 0;
      foreach (n_status[i]) n_status[i] = 0;
    endfunction

    // bit-serial form: feedback is the top bit xor the incoming data bit
    function logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ b[i];
        c  = {c[14:0], 1'b0};
        if (fb) c = c ^ CrcPoly;
      end
      return c;
    endfunction

    function bit len_ok(input logic [15:0] len);
      return !(len < HeaderLen || len > MaxFrameDef || len[1:0] != 2'b00);
    endfunction

    function void expect_report(input logic [1:0] st);
      res_t e;
      e.frame_status   = st;
      e.block_number   = ident[12:0];
      e.block_revision = ident[15:13];
      e.frame_bytes    = len_field;
      report_q.push_back(e);
      phase = PhaseSync1;
      pos   = 0;
    endfunction

    function void note_byte(input logic [7:0] b);
      case (phase)
        PhaseSync1: begin
          if (b == SyncFirst) begin
            phase = PhaseSync2;
            pos   = 1;
          end
        end
        PhaseSync2: begin
          if (b == SyncSecond) begin
            phase     = PhaseBody;
            pos       = 2;
            crc_run   = '0;
            len_field = '0;
          end else if (b == SyncFirst) begin
            pos = 1;
          end else begin
            phase = PhaseSync1;
            pos   = 0;
          end
        end
        PhaseBody: begin
          case (pos)
            PosCrcLo: crc_field = {8'h00, b};
            PosCrcHi: crc_field[15:8] = b;
            PosIdLo:  ident = {8'h00, b};
            PosIdHi:  ident[15:8] = b;
            PosLenLo: len_field = {8'h00, b};
            PosLenHi: len_field[15:8] = b;
            default: ;
          endcase
          if (pos >= PosIdLo) crc_run = crc_next(crc_run, b);
          pos++;
          if (pos == HeaderLen) begin
            if (!len_ok(len_field)) begin
              expect_report(StatusBadLen);
            end else if (len_field == HeaderLen) begin
              expect_report(crc_run == crc_field ? StatusGood : StatusCrcBad);
            end
          end else if (pos > HeaderLen && (pos == len_field || pos > MaxFrameDef)) begin
            expect_report(crc_run == crc_field ? StatusGood : StatusCrcBad);
          end
        end
        default: begin
          phase = PhaseSync1;
          pos   = 0;
        end
      endcase
    endfunction

    task report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      n_err++;
    endtask

    task check_result(input res_t got);
      res_t want;
      if (report_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result word %p", got));
      end else begin
        want = report_q.pop_front();
        n_reports++;
        if (got.frame_status <= StatusBadLen) n_status[got.frame_status]++;
        if (got.frame_status !== want.frame_status)
          report_mismatch($sformatf("frame_status %0d, want %0d",
                                    got.frame_status, want.frame_status));
        if (got.block_number !== want.block_number)
          report_mismatch($sformatf("block_number %0d, want %0d",
                                    got.block_number, want.block_number));
        if (got.block_revision !== want.block_revision)
          report_mismatch($sformatf("block_revision %0d, want %0d",
                                    got.block_revision, want.block_revision));
        if (got.frame_bytes !== want.frame_bytes)
          report_mismatch($sformatf("frame_bytes %0d, want %0d",
                                    got.frame_bytes, want.frame_bytes));
      end
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  frame_status_o;
  logic [12:0] block_number_o;
  logic [2:0]  block_revision_o;
  logic [15:0] frame_bytes_o;

  frame_scoreboard sb;
  int src_idle;
  int sink_idle;
  int sent;
  bit hold_armed;
  int hold_cycles;

  gnss_block_frame_sync_crc16_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .frame_status_o   (frame_status_o),
    .block_number_o   (block_number_o),
    .block_revision_o (block_revision_o),
    .frame_bytes_o    (frame_bytes_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

  // result side: random stalls, plus one long hold-off counted here
  initial begin
    out_stall_i <= 1'b0;
    hold_cycles = 0;
    forever begin
      @(posedge clk_i);
      if (hold_armed && hold_cycles < 300) begin
        out_stall_i <= 1'b1;
        hold_cycles++;
      end else begin
        out_stall_i <= ($urandom_range(99) < sink_idle);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        sb.check_result(res_t'({frame_status_o, block_number_o, block_revision_o,
                                frame_bytes_o}));
      if (in_valid_i && !in_stall_o) sb.note_byte(data_byte_i);
    end
  end

  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  // drop in_valid_i and wait for the clock first so the last accepted word has been noted
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.report_q.size() != 0) @(posedge clk_i);
  endtask

  // sync bytes turn up in payloads often enough to show they are ignored there
  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(15);
    if (r == 0) return SyncFirst;
    if (r == 1) return SyncSecond;
    return 8'($urandom_range(255));
  endfunction

  // keep < 0 sends the whole frame, otherwise only its first keep words
  task automatic send_frame(input logic [15:0] ident, input logic [15:0] len,
                            input bit spoil, input int keep);
    logic [7:0]  body[$];
    logic [7:0]  words[$];
    logic [15:0] crc;
    int          n_pay;
    body.push_back(ident[7:0]);
    body.push_back(ident[15:8]);
    body.push_back(len[7:0]);
    body.push_back(len[15:8]);
    n_pay = sb.len_ok(len) ? int'(len) - int'(HeaderLen) : 0;
    repeat (n_pay) body.push_back(rand_byte());
    crc = '0;
    foreach (body[i]) crc = sb.crc_next(crc, body[i]);
    if (spoil) crc = crc ^ 16'($urandom_range(65534) + 1);
    words.push_back(SyncFirst);
    words.push_back(SyncSecond);
    words.push_back(crc[7:0]);
    words.push_back(crc[15:8]);
    foreach (body[i]) words.push_back(body[i]);
    foreach (words[i]) begin
      if (keep < 0 || i < keep) push_byte(words[i]);
    end
  endtask

  function automatic logic [15:0] rand_good_len();
    if ($urandom_range(39) == 0) return 16'(4 * $urandom_range(17, 40));
    if ($urandom_range(9) == 0) return 16'(4 * $urandom_range(2, 16));
    return 16'(4 * $urandom_range(2, 10));
  endfunction

  function automatic logic [15:0] rand_bad_len();
    case ($urandom_range(3))
      0: return 16'($urandom_range(7));
      1: return 16'(4 * $urandom_range(2, 255) + $urandom_range(1, 3));
      2: return 16'($urandom_range(MaxFrameDef + 1, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_frame();
    int r;
    r = $urandom_range(99);
    if (r < 70) begin
      send_frame(16'($urandom), rand_good_len(), 1'b0, -1);
    end else if (r < 80) begin
      send_frame(16'($urandom), rand_good_len(), 1'b1, -1);
    end else if (r < 88) begin
      send_frame(16'($urandom), rand_bad_len(), $urandom_range(1), -1);
    end else if (r < 93) begin
      send_frame(16'($urandom), rand_good_len(), 1'b0, $urandom_range(1, 12));
    end else if (r < 97) begin
      // aborted hunt: first sync, maybe repeated, then junk
      push_byte(SyncFirst);
      if ($urandom_range(1)) push_byte(SyncFirst);
      push_byte(8'($urandom_range(SyncSecond + 1, 255)));
    end else begin
      repeat ($urandom_range(1, 4)) push_byte(rand_byte());
    end
  endtask

  task automatic run_random(input int n_words);
    int start;
    start = sent;
    while (sent - start < n_words) random_frame();
  endtask

  initial begin
    sb          = new();
    sent        = 0;
    hold_armed  = 1'b0;
    src_idle    = 28;
    sink_idle   = 86;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    data_byte_i <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: junk while hunting, re-armed and dropped hunts, header-only
    // frames, each kind of bad length, sync inside a frame, a longer frame
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(SyncFirst);
    send_frame(16'hFFFF, HeaderLen, 1'b0, -1);
    push_byte(SyncFirst);
    push_byte(8'h13);
    push_byte(SyncSecond);
    send_frame(16'h0000, HeaderLen, 1'b1, -1);
    send_frame(16'h2001, 16'd4, 1'b0, -1);
    send_frame(16'hE000, 16'd0, 1'b0, -1);
    send_frame(16'h1FFF, 16'd10, 1'b0, -1);
    send_frame(16'h5A5A, 16'(MaxFrameDef + 4), 1'b0, -1);
    send_frame(16'hA5A5, 16'hFFFF, 1'b0, -1);
    send_frame(16'h1234, 16'd12, 1'b0, -1);
    send_frame(16'h8421, 16'd16, 1'b1, -1);
    send_frame(16'h7777, 16'd100, 1'b0, -1);

    run_random(190);

    // long hold-off on results while words keep coming
    wait_drain();
    src_idle   = 0;
    hold_armed = 1'b1;
    repeat (30) send_frame(16'($urandom), HeaderLen, $urandom_range(1), -1);
    wait_drain();
    hold_armed = 1'b0;

    src_idle  = 86;
    sink_idle = 28;
    run_random(190);
    src_idle  = 0;
    sink_idle = 0;
    run_random(180);

    wait_drain();
    repeat (20) @(posedge clk_i);
    if (sb.report_q.size() != 0)
      sb.report_mismatch($sformatf("%0d frame reports never came out", sb.report_q.size()));
    $display("Sent %0d bytes; checked %0d frame reports (%0d good, %0d crc error, %0d bad length)",
             sent, sb.n_reports, sb.n_status[StatusGood], sb.n_status[StatusCrcBad],
             sb.n_status[StatusBadLen]);
    $display("Covered sync hunting, header-only, long and bad-length frames, and a long result stall");
    if (sb.n_err == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/gfsc_pkg.sv
sv/gfsc_in_reg.sv
sv/gfsc_parser.sv
sv/gfsc_out_fifo.sv
sv/gnss_block_frame_sync_crc16_unit.sv
dv/gnss_block_frame_sync_crc16_unit_tb.sv
